// File: rtl/cvm_pkg.sv
// Shared types and constants for the camera view matrix generator.
package cvm_pkg;

   localparam int ANGLE_W = 17;
   localparam int ENTRY_W = 18;
   localparam int POS_W = 32;
   localparam int CORDIC_W = 34;
   localparam int ZACC_W = 26;
   localparam int PROD_W = ENTRY_W + POS_W;
   localparam int ACC_W = PROD_W + 2;
   localparam int STEPS = 16;

   localparam logic signed [18:0] PITCH_LIMIT = 19'sd23040;
   localparam logic signed [18:0] TURN = 19'sd92160;
   localparam logic signed [18:0] HALF_TURN = 19'sd46080;
   localparam logic signed [18:0] QUARTER_TURN = 19'sd23040;
   localparam logic signed [CORDIC_W-1:0] CORDIC_GAIN = 34'sd652032874;
   localparam logic signed [ENTRY_W-1:0] ONE_Q16 = 18'sd65536;

   // CORDIC arctangent table, degrees in Q16.16
   function automatic logic signed [ZACC_W-1:0] atan_deg(input logic [3:0] i);
      logic signed [ZACC_W-1:0] r;
      case (i)
         4'd0: r = 26'sd2949120;
         4'd1: r = 26'sd1740967;
         4'd2: r = 26'sd919879;
         4'd3: r = 26'sd466945;
         4'd4: r = 26'sd234379;
         4'd5: r = 26'sd117304;
         4'd6: r = 26'sd58666;
         4'd7: r = 26'sd29335;
         4'd8: r = 26'sd14668;
         4'd9: r = 26'sd7334;
         4'd10: r = 26'sd3667;
         4'd11: r = 26'sd1833;
         4'd12: r = 26'sd917;
         4'd13: r = 26'sd458;
         4'd14: r = 26'sd229;
         default: r = 26'sd115;
      endcase
      return r;
   endfunction

   // sine/cosine result handed from the CORDIC unit to the sequencer
   typedef struct packed {
      logic done;
      logic signed [ENTRY_W-1:0] sin_v;
      logic signed [ENTRY_W-1:0] cos_v;
   } cvm_trig_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_PSTART,
      ST_PWAIT,
      ST_YSTART,
      ST_YWAIT,
      ST_MAC,
      ST_OUT
   } cvm_state_type;

   // multiply steps: four entry products, then nine dot-product terms
   localparam logic [3:0] MUL_ENTRIES = 4'd4;
   localparam logic [3:0] MUL_LAST = 4'd13;

endpackage

// File: rtl/cvm_cordic.sv
// Iterative rotation-mode CORDIC giving sine and cosine of a Q8.8 angle.
module cvm_cordic (
   input  logic clock,
   input  logic reset,
   input  logic start,
   input  logic signed [cvm_pkg::ANGLE_W-1:0] angle,
   output cvm_pkg::cvm_trig_type trig
);
   import cvm_pkg::*;

   logic signed [CORDIC_W-1:0] x_ff, x_in, y_ff, y_in;
   logic signed [ZACC_W-1:0] z_ff, z_in;
   logic [3:0] iter_ff, iter_in;
   logic busy_ff, busy_in, done_ff, done_in, flip_ff, flip_in;
   logic signed [18:0] a_wrap, a_fold;
   logic a_flip;
   logic signed [CORDIC_W-15:0] x_rnd, y_rnd;
   logic signed [ENTRY_W-1:0] x_cl, y_cl;

   // reduce into [-180,180) then fold into [-90,90]
   always_comb begin
      a_wrap = 19'(angle);
      if (a_wrap >= HALF_TURN) a_wrap = a_wrap - TURN;
      else if (a_wrap < -HALF_TURN) a_wrap = a_wrap + TURN;
      a_fold = a_wrap;
      a_flip = 1'b0;
      if (a_wrap > QUARTER_TURN) begin
         a_fold = HALF_TURN - a_wrap;
         a_flip = 1'b1;
      end else if (a_wrap < -QUARTER_TURN) begin
         a_fold = -HALF_TURN - a_wrap;
         a_flip = 1'b1;
      end
   end

   // one micro-rotation per cycle
   always_comb begin
      x_in = x_ff;
      y_in = y_ff;
      z_in = z_ff;
      iter_in = iter_ff;
      busy_in = busy_ff;
      flip_in = flip_ff;
      done_in = 1'b0;
      if (start) begin
         x_in = CORDIC_GAIN;
         y_in = '0;
         z_in = ZACC_W'(a_fold) <<< 8;
         iter_in = '0;
         busy_in = 1'b1;
         flip_in = a_flip;
      end else if (busy_ff) begin
         if (z_ff >= 0) begin
            x_in = x_ff - (y_ff >>> iter_ff);
            y_in = y_ff + (x_ff >>> iter_ff);
            z_in = z_ff - atan_deg(iter_ff);
         end else begin
            x_in = x_ff + (y_ff >>> iter_ff);
            y_in = y_ff - (x_ff >>> iter_ff);
            z_in = z_ff + atan_deg(iter_ff);
         end
         iter_in = iter_ff + 4'd1;
         if (iter_ff == 4'(STEPS - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      x_ff <= x_in;
      y_ff <= y_in;
      z_ff <= z_in;
      iter_ff <= iter_in;
      flip_ff <= flip_in;
   end

   // round Q2.30 to Q16.16 and clamp to +-1
   always_comb begin
      x_rnd = 20'((x_ff + 34'sd8192) >>> 14);
      y_rnd = 20'((y_ff + 34'sd8192) >>> 14);
      if (x_rnd > 20'(ONE_Q16)) x_cl = ONE_Q16;
      else if (x_rnd < -20'(ONE_Q16)) x_cl = -ONE_Q16;
      else x_cl = ENTRY_W'(x_rnd);
      if (y_rnd > 20'(ONE_Q16)) y_cl = ONE_Q16;
      else if (y_rnd < -20'(ONE_Q16)) y_cl = -ONE_Q16;
      else y_cl = ENTRY_W'(y_rnd);
      trig.done = done_ff;
      trig.sin_v = y_cl;
      trig.cos_v = flip_ff ? -x_cl : x_cl;
   end

endmodule

// File: rtl/cvm_mul.sv
// Shared signed 18x32 multiplier with a registered product.
module cvm_mul (
   input  logic clock,
   input  logic signed [cvm_pkg::ENTRY_W-1:0] op_a,
   input  logic signed [cvm_pkg::POS_W-1:0] op_b,
   output logic signed [cvm_pkg::PROD_W-1:0] prod
);
   import cvm_pkg::*;

   logic signed [PROD_W-1:0] prod_ff;

   always_ff @(posedge clock) begin
      prod_ff <= PROD_W'(op_a) * PROD_W'(op_b);
   end

   assign prod = prod_ff;

endmodule

// File: rtl/camera_view_matrix_generator_core.sv
// Processing: two 16-step CORDIC passes, then the multiply sequence on the
//   shared multiplier.
// Throughput: one item at a time; next item taken after the result is taken.
// The CORDIC iteration and the single multiplier set the processing time.
// Reset (synchronous, active high) clears pitch, yaw, position and control.
module camera_view_matrix_generator_core (
   input  logic clock,
   input  logic reset,
   input  logic req_tvalid,
   output logic req_tready,
   input  logic [135:0] req_tdata, // pitch_deg, yaw_deg, pos_x, pos_y, pos_z, zero pad
   input  logic [0:0] req_tuser,   // operation
   output logic rsp_tvalid,
   input  logic rsp_tready,
   output logic [263:0] rsp_tdata  // row0_col0..col3, row1_col0..col3, row2_col0..col3, pad
);
   import cvm_pkg::*;

   cvm_state_type state_ff, state_in;
   logic signed [ANGLE_W-1:0] pitch_ff, pitch_in, yaw_ff, yaw_in;
   logic signed [POS_W-1:0] pos_ff [3];
   logic signed [POS_W-1:0] pos_in [3];
   logic signed [ENTRY_W-1:0] e_ff [9];
   logic signed [ENTRY_W-1:0] sp_ff, cp_ff;
   logic signed [POS_W-1:0] col3_ff [3];
   logic signed [ACC_W-1:0] acc_ff, acc_in;
   logic [3:0] cnt_ff, cnt_in;
   logic cordic_start;
   logic signed [ANGLE_W-1:0] cordic_angle;
   cvm_trig_type trig;
   logic signed [ENTRY_W-1:0] op_a;
   logic signed [POS_W-1:0] op_b;
   logic signed [PROD_W-1:0] prod;
   logic [3:0] idx;
   logic [1:0] row_sel, col_sel, op_row, op_col;
   logic signed [ENTRY_W-1:0] mulq_v;
   logic signed [ACC_W-1:0] sum_v;
   logic signed [ACC_W:0] t_v;
   logic signed [POS_W-1:0] col3_v;
   logic accept;

   logic signed [ANGLE_W-1:0] d_pitch, d_yaw;
   logic signed [18:0] p_sum, y_sum;
   logic signed [POS_W:0] s_pos [3];

   assign accept = req_tvalid && req_tready;
   assign d_pitch = req_tdata[16:0];
   assign d_yaw = req_tdata[33:17];

   // pose update: set, or add with pitch clamped, yaw wrapped and position saturated
   always_comb begin
      p_sum = 19'(pitch_ff) + 19'(d_pitch);
      if (req_tuser[0]) pitch_in = d_pitch;
      else if (p_sum > PITCH_LIMIT) pitch_in = ANGLE_W'(PITCH_LIMIT);
      else if (p_sum < -PITCH_LIMIT) pitch_in = ANGLE_W'(-PITCH_LIMIT);
      else pitch_in = ANGLE_W'(p_sum);
      y_sum = req_tuser[0] ? 19'(d_yaw) : 19'(yaw_ff) + 19'(d_yaw);
      if (y_sum >= HALF_TURN) y_sum = y_sum - TURN;
      else if (y_sum < -HALF_TURN) y_sum = y_sum + TURN;
      yaw_in = ANGLE_W'(y_sum);
      for (int k = 0; k < 3; k++) begin
         s_pos[k] = 33'(pos_ff[k]) + 33'($signed(req_tdata[34 + 32*k +: 32]));
         if (req_tuser[0]) pos_in[k] = req_tdata[34 + 32*k +: 32];
         else if (s_pos[k][POS_W] != s_pos[k][POS_W-1])
            pos_in[k] = s_pos[k][POS_W] ? {1'b1, {(POS_W-1){1'b0}}}
                                        : {1'b0, {(POS_W-1){1'b1}}};
         else pos_in[k] = s_pos[k][POS_W-1:0];
      end
   end

   cvm_cordic u_cordic (
      .clock(clock),
      .reset(reset),
      .start(cordic_start),
      .angle(cordic_angle),
      .trig(trig)
   );

   assign cordic_start = (state_ff == ST_PSTART) || (state_ff == ST_YSTART);
   assign cordic_angle = (state_ff == ST_PSTART) ? pitch_ff : yaw_ff;

   // operand selection for the multiply sequence
   always_comb begin
      op_row = 2'd0;
      op_col = 2'd0;
      case (cnt_ff)
         4'd4: begin op_row = 2'd0; op_col = 2'd0; end
         4'd5: begin op_row = 2'd0; op_col = 2'd1; end
         4'd6: begin op_row = 2'd0; op_col = 2'd2; end
         4'd7: begin op_row = 2'd1; op_col = 2'd0; end
         4'd8: begin op_row = 2'd1; op_col = 2'd1; end
         4'd9: begin op_row = 2'd1; op_col = 2'd2; end
         4'd10: begin op_row = 2'd2; op_col = 2'd0; end
         4'd11: begin op_row = 2'd2; op_col = 2'd1; end
         4'd12: begin op_row = 2'd2; op_col = 2'd2; end
         default: begin op_row = 2'd0; op_col = 2'd0; end
      endcase
      case (cnt_ff)
         4'd0: begin op_a = sp_ff; op_b = POS_W'(e_ff[2]); end
         4'd1: begin op_a = -sp_ff; op_b = POS_W'(e_ff[0]); end
         4'd2: begin op_a = -cp_ff; op_b = POS_W'(e_ff[2]); end
         4'd3: begin op_a = cp_ff; op_b = POS_W'(e_ff[0]); end
         default: begin
            op_a = e_ff[4'(op_row) * 4'd3 + 4'(op_col)];
            op_b = pos_ff[op_col];
         end
      endcase
   end

   cvm_mul u_mul (
      .clock(clock),
      .op_a(op_a),
      .op_b(op_b),
      .prod(prod)
   );

   // product of the previous step
   assign idx = cnt_ff - 4'd1;
   always_comb begin
      case (idx)
         4'd7, 4'd8, 4'd9: row_sel = 2'd1;
         4'd10, 4'd11, 4'd12: row_sel = 2'd2;
         default: row_sel = 2'd0;
      endcase
      case (idx)
         4'd5, 4'd8, 4'd11: col_sel = 2'd1;
         4'd6, 4'd9, 4'd12: col_sel = 2'd2;
         default: col_sel = 2'd0;
      endcase
      mulq_v = ENTRY_W'((prod + PROD_W'(32768)) >>> 16);
      sum_v = (col_sel == 2'd0) ? ACC_W'(prod) : acc_ff + ACC_W'(prod);
      t_v = ((-(ACC_W+1)'(sum_v)) + (ACC_W+1)'(32768)) >>> 16;
      if (t_v > (ACC_W+1)'(32'sh7fffffff)) col3_v = {1'b0, {(POS_W-1){1'b1}}};
      else if (t_v < -(ACC_W+1)'(33'sh080000000)) col3_v = {1'b1, {(POS_W-1){1'b0}}};
      else col3_v = POS_W'(t_v);
   end

   // sequencer
   always_comb begin
      state_in = state_ff;
      cnt_in = cnt_ff;
      acc_in = acc_ff;
      req_tready = 1'b0;
      rsp_tvalid = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) state_in = ST_PSTART;
         end
         ST_PSTART: state_in = ST_PWAIT;
         ST_PWAIT: if (trig.done) state_in = ST_YSTART;
         ST_YSTART: state_in = ST_YWAIT;
         ST_YWAIT: begin
            cnt_in = '0;
            if (trig.done) state_in = ST_MAC;
         end
         ST_MAC: begin
            cnt_in = cnt_ff + 4'd1;
            if (cnt_ff != 4'd0) acc_in = sum_v;
            if (cnt_ff == MUL_LAST) state_in = ST_OUT;
         end
         ST_OUT: begin
            rsp_tvalid = 1'b1;
            if (rsp_tready) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         pitch_ff <= '0;
         yaw_ff <= '0;
         for (int k = 0; k < 3; k++) pos_ff[k] <= '0;
      end else begin
         state_ff <= state_in;
         if (accept) begin
            pitch_ff <= pitch_in;
            yaw_ff <= yaw_in;
            for (int k = 0; k < 3; k++) pos_ff[k] <= pos_in[k];
         end
      end
      cnt_ff <= cnt_in;
      acc_ff <= acc_in;
      if (state_ff == ST_PWAIT && trig.done) begin
         sp_ff <= trig.sin_v;
         cp_ff <= trig.cos_v;
      end
      if (state_ff == ST_YWAIT && trig.done) begin
         e_ff[0] <= trig.cos_v;
         e_ff[1] <= '0;
         e_ff[2] <= trig.sin_v;
         e_ff[4] <= cp_ff;
         e_ff[7] <= sp_ff;
      end
      if (state_ff == ST_MAC && cnt_ff != 4'd0) begin
         if (idx < MUL_ENTRIES) begin
            case (idx)
               4'd0: e_ff[3] <= mulq_v;
               4'd1: e_ff[5] <= mulq_v;
               4'd2: e_ff[6] <= mulq_v;
               default: e_ff[8] <= mulq_v;
            endcase
         end else if (col_sel == 2'd2) begin
            col3_ff[row_sel] <= col3_v;
         end
      end
   end

   assign rsp_tdata = {6'd0,
                       col3_ff[2], e_ff[8], e_ff[7], e_ff[6],
                       col3_ff[1], e_ff[5], e_ff[4], e_ff[3],
                       col3_ff[0], e_ff[2], e_ff[1], e_ff[0]};

endmodule

// File: rtl/cvm_checker.sv
// Port-level checks for the camera view matrix generator, bound to the top level.
module cvm_checker (
   input logic clock,
   input logic reset,
   input logic req_tvalid,
   input logic req_tready,
   input logic rsp_tvalid,
   input logic rsp_tready,
   input logic [263:0] rsp_tdata
);

   // a waiting result holds still
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result changed while stalled");

   // block is busy right after taking an item
   assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready && !rsp_tvalid)
      else $error("item taken while busy or result too early");

   // no input taken while a result is offered
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !req_tready)
      else $error("ready while result pending");

   // row 0 column 1 is always zero
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[35:18] == 18'd0)
      else $error("row0_col1 nonzero");

endmodule

bind camera_view_matrix_generator_core cvm_checker u_cvm_checker (
   .clock(clock),
   .reset(reset),
   .req_tvalid(req_tvalid),
   .req_tready(req_tready),
   .rsp_tvalid(rsp_tvalid),
   .rsp_tready(rsp_tready),
   .rsp_tdata(rsp_tdata)
);

// File: dv/tb.sv
// Testbench for the camera view matrix generator core: pose updates in, view rows out.
`timescale 1ns / 100ps

module tb;
   import cvm_pkg::*;

   localparam int OP_ADD = 0;
   localparam int OP_SET = 1;
   localparam int Q_PITCH_LIM = 23040;
   localparam int Q_TURN = 92160;
   localparam int Q_HALF = 46080;
   localparam int Q_QUARTER = 23040;
   localparam longint I32_MIN = -64'sd2147483648;
   localparam longint I32_MAX = 64'sd2147483647;

   typedef struct {
      longint ent[3][4];
   } view_rows_type;

   logic clock = 0;
   logic reset = 1;
   logic req_tvalid = 0;
   logic req_tready;
   logic [135:0] req_tdata = '0; // pitch_deg, yaw_deg, pos_x, pos_y, pos_z, pad
   logic [0:0] req_tuser = '0;   // operation
   logic rsp_tvalid;
   logic rsp_tready = 0;
   logic [263:0] rsp_tdata;      // row0_col0..col3, row1_col0..col3, row2_col0..col3, pad

   int send_idle_pct = 0;
   int recv_idle_pct = 0;
   int hold_off = 0;
   int errors = 0;

   // camera pose mirror
   longint cam_pitch = 0, cam_yaw = 0;
   longint cam_pos[3] = '{0, 0, 0};
   view_rows_type pending_views[$];

   camera_view_matrix_generator_core dut (.*);

   initial forever #2 clock = ~clock;

   initial begin
      #20ms;
      $display("TB_ERROR");
      $finish;
   end

   function automatic longint asr(longint v, int s);
      return v >>> s;
   endfunction

   function automatic longint clip(longint v, longint lo, longint hi);
      return v < lo ? lo : (v > hi ? hi : v);
   endfunction

   function automatic longint wrap_angle(longint a);
      longint r;
      r = a % Q_TURN;
      if (r < 0) r += Q_TURN;
      if (r >= Q_HALF) r -= Q_TURN;
      return r;
   endfunction

   task automatic trig(input longint angle, output longint s, output longint c);
      longint atan_tab[16] = '{2949120, 1740967, 919879, 466945, 234379, 117304, 58666,
         29335, 14668, 7334, 3667, 1833, 917, 458, 229, 115};
      longint a, x, y, z, dx, dy;
      bit flip;
      a = wrap_angle(angle);
      flip = 0;
      x = 652032874;
      y = 0;
      if (a > Q_QUARTER) begin
         a = Q_HALF - a;
         flip = 1;
      end else if (a < -Q_QUARTER) begin
         a = -Q_HALF - a;
         flip = 1;
      end
      z = a * 256;
      for (int i = 0; i < 16; i++) begin
         dx = asr(y, i);
         dy = asr(x, i);
         if (z >= 0) begin
            x -= dx; y += dy; z -= atan_tab[i];
         end else begin
            x += dx; y -= dy; z += atan_tab[i];
         end
      end
      x = clip(asr(x + 8192, 14), -65536, 65536);
      y = clip(asr(y + 8192, 14), -65536, 65536);
      c = flip ? -x : x;
      s = y;
   endtask

   function automatic longint mul_q16(longint a, longint b);
      return asr(a * b + 32768, 16);
   endfunction

   // update the pose and build the expected view rows
   task automatic predict_view(input bit op, input longint dp, input longint dyw,
                               input longint px[3]);
      view_rows_type v;
      longint sp, cp, sy, cy, t, e;
      if (op == OP_SET) begin
         cam_pitch = dp;
         cam_yaw = wrap_angle(dyw);
         for (int k = 0; k < 3; k++) cam_pos[k] = px[k];
      end else begin
         cam_pitch = clip(cam_pitch + dp, -Q_PITCH_LIM, Q_PITCH_LIM);
         cam_yaw = wrap_angle(cam_yaw + dyw);
         for (int k = 0; k < 3; k++) cam_pos[k] = clip(cam_pos[k] + px[k], I32_MIN, I32_MAX);
      end
      trig(cam_pitch, sp, cp);
      trig(cam_yaw, sy, cy);
      v.ent[0][0] = cy;              v.ent[0][1] = 0;  v.ent[0][2] = sy;
      v.ent[1][0] = mul_q16(sp, sy); v.ent[1][1] = cp; v.ent[1][2] = mul_q16(-sp, cy);
      v.ent[2][0] = mul_q16(-cp, sy); v.ent[2][1] = sp; v.ent[2][2] = mul_q16(cp, cy);
      for (int r = 0; r < 3; r++) begin
         t = 0;
         for (int k = 0; k < 3; k++) begin
            e = clip(v.ent[r][k], -65536, 65536);
            v.ent[r][k] = e;
            t += e * cam_pos[k];
         end
         v.ent[r][3] = clip(asr(-t + 32768, 16), I32_MIN, I32_MAX);
      end
      pending_views.push_back(v);
   endtask

   // send one pose update; valid stays up into the next item unless the sender idles
   task automatic send_pose(input bit op, input longint dp, input longint dyw,
                            input longint px[3]);
      while (send_idle_pct != 0 && $urandom_range(99, 0) < send_idle_pct) begin
         req_tvalid <= 0;
         @(negedge clock);
      end
      req_tvalid <= 1;
      req_tuser <= op;
      req_tdata <= {6'd0, px[2][31:0], px[1][31:0], px[0][31:0], dyw[16:0], dp[16:0]};
      predict_view(op, dp, dyw, px);
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      @(negedge clock);
   endtask

   // receiver ready
   always @(negedge clock) begin
      if (hold_off > 0) begin
         hold_off <= hold_off - 1;
         rsp_tready <= 0;
      end else
         rsp_tready <= !(recv_idle_pct != 0 && $urandom_range(99, 0) < recv_idle_pct);
   end

   // result check
   always @(posedge clock) begin
      view_rows_type v;
      longint got;
      int w;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_views.size() == 0) begin
            $error("view rows with none expected");
            errors++;
         end else begin
            v = pending_views.pop_front();
            w = 0;
            for (int r = 0; r < 3; r++)
               for (int c = 0; c < 4; c++) begin
                  if (c == 3) begin
                     got = $signed(rsp_tdata[w +: 32]);
                     w += 32;
                  end else begin
                     got = $signed(rsp_tdata[w +: 18]);
                     w += 18;
                  end
                  if (got != v.ent[r][c]) begin
                     $error("row%0d_col%0d expected %0d got %0d", r, c, v.ent[r][c], got);
                     errors++;
                  end
               end
         end
      end
   end

   function automatic longint rnd_angle();
      return longint'($urandom_range(92159, 0)) - 46080;
   endfunction

   function automatic longint rnd_pos();
      case ($urandom_range(3, 0))
         0: return longint'($signed($urandom()));
         1: return longint'($urandom_range(131072, 0)) - 65536;
         2: return $urandom_range(1, 0) ? I32_MAX : I32_MIN;
         default: return longint'($signed($urandom())) >>> $urandom_range(24, 8);
      endcase
   endfunction

   task automatic test_directed();
      longint p0[3] = '{0, 0, 0};
      longint pmax[3] = '{I32_MAX, I32_MAX, I32_MAX};
      longint pmin[3] = '{I32_MIN, I32_MIN, I32_MIN};
      longint pmix[3] = '{65536, -131072, 3 << 16};
      send_pose(OP_SET, 0, 0, p0);
      send_pose(OP_SET, 46079, 46079, pmax);
      send_pose(OP_SET, -46080, -46080, pmin);
      send_pose(OP_ADD, 0, 0, pmin);        // position saturates low
      send_pose(OP_SET, 0, 0, pmax);
      send_pose(OP_ADD, 0, 0, pmax);        // position saturates high
      send_pose(OP_SET, 20000, 23040, pmix);
      send_pose(OP_ADD, 10000, 23040, p0);  // pitch clamps at +90, yaw past 180
      send_pose(OP_ADD, -46080, -46080, p0); // pitch clamps at -90
      send_pose(OP_ADD, 46079, 46079, p0);
      send_pose(OP_SET, 23040, -23040, pmix);
      send_pose(OP_SET, -23041, 23041, pmix);
      send_pose(OP_SET, 30000, -46080, pmix); // set pitch beyond 90 is kept
      send_pose(OP_ADD, 1, -1, pmix);
      send_pose(OP_SET, 11520, 34560, pmix);
   endtask

   task automatic test_random(input int count);
      longint px[3];
      bit op;
      for (int i = 0; i < count; i++) begin
         op = $urandom_range(3, 0) == 0;
         for (int k = 0; k < 3; k++) px[k] = rnd_pos();
         send_pose(op, $urandom_range(3, 0) == 0 ? rnd_angle() :
                   longint'($urandom_range(4000, 0)) - 2000, rnd_angle(), px);
      end
   endtask

   task automatic test_backpressure();
      hold_off = 400;
      test_random(20);
   endtask

   initial begin
      int waited;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 0;
      test_directed();
      send_idle_pct = 9;
      recv_idle_pct = 76;
      test_random(280);
      send_idle_pct = 76;
      recv_idle_pct = 9;
      test_random(280);
      send_idle_pct = 0;
      recv_idle_pct = 0;
      test_backpressure();
      test_random(260);
      req_tvalid <= 0;
      waited = 0;
      while (pending_views.size() != 0 && waited < 100000) begin
         @(posedge clock);
         waited++;
      end
      repeat (100) @(posedge clock);
      if (errors == 0 && pending_views.size() == 0)
         $display("TB_OK");
      else
         $display("TB_ERROR");
      $finish;
   end
endmodule
